/* rtl/v3n_pkg.sv */
// ----------------------------------------------------------------------------
// v3n_pkg: shared widths and types for the vector normalizer
// Holds field widths, pipeline depths and the per-stage payload struct.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int unsigned CompW   = 16;            // component width
  localparam int unsigned MagW    = 17;            // magnitude of a component
  localparam int unsigned SumW    = 32;            // sum of squares
  localparam int unsigned RootW   = 16;            // floor root
  localparam int unsigned QW      = 17;            // quotient before saturation
  localparam int unsigned NumW    = 31;            // magnitude * 16384
  localparam int unsigned SqSteps = 16;            // one root bit per stage
  // first step takes the top 16 dividend bits, then one bit per stage
  localparam int unsigned DivSteps = 16;
  localparam logic [QW-1:0] QOne  = 17'd16384;

  // one component carried through the divider
  typedef struct packed {
    logic            neg;
    logic [NumW-1:0] num;     // dividend, shifted out MSB first
    logic [QW-1:0]   quo;     // partial quotient
    logic [RootW:0]  rem;     // partial remainder
  } v3n_div_t;

endpackage

/* rtl/vector3_normalise.sv */
// ----------------------------------------------------------------------------
// vector3_normalise: three-component vector normalizer
// Sum of squares, floor square root and three Q2.14 unit components.
// ----------------------------------------------------------------------------
// One vector can enter per clock. It passes a square stage (registered on the
// accepting edge), then 1 sum stage, 16 root stages, 16 divide stages and 1
// output stage before its result is offered.
// The root takes one bit per stage, then the three components are divided
// in parallel restoring dividers, one quotient bit per stage. All stages
// advance together whenever the output register is free or taken, so a
// steady stream runs at one vector per cycle; a stall holds every stage.
module vector3_normalise
  import v3n_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // in_x[15:0], in_y[31:16], in_z[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // out_x, out_y, out_z, length (low first)
);

  localparam int unsigned NStage = 2 + SqSteps + DivSteps;

  // global advance: whole pipe moves when the output slot can take data
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic [NStage-1:0] vld_q;

  // ---------------- stage 0: magnitudes and squares ----------------
  logic [2:0]          s0_neg_q;
  logic [MagW-1:0]     s0_mag_q [3];
  logic [SumW-1:0]     s0_sq_q  [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [CompW-1:0] c;
        logic [MagW-1:0]         m;
        c = s_axis_tdata[i*CompW +: CompW];
        m = c[CompW-1] ? MagW'(-$signed({c[CompW-1], c})) : MagW'(c);
        s0_neg_q[i] <= c[CompW-1];
        s0_mag_q[i] <= m;
        s0_sq_q[i]  <= SumW'(m) * SumW'(m);
      end
    end
  end

  // ---------------- root and divider storage ----------------
  logic [SumW-1:0]  rt_rem_q  [SqSteps];
  logic [RootW-1:0] rt_root_q [SqSteps];
  logic [2:0]       rt_neg_q  [SqSteps];
  logic [MagW-1:0]  rt_mag_q  [SqSteps][3];

  v3n_div_t         dv_q   [DivSteps+1][3];
  logic [RootW-1:0] dv_len_q [DivSteps+1];
  logic [RootW-1:0] dv_dvs   [DivSteps];

  // ---------------- stage 1: sum, loads the first root stage ----------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_neg_q[0]  <= s0_neg_q;
      rt_mag_q[0]  <= s0_mag_q;
      rt_rem_q[0]  <= s0_sq_q[0] + s0_sq_q[1] + s0_sq_q[2];
      rt_root_q[0] <= '0;
    end
  end

  // ---------------- root stages: one result bit each ----------------
  for (genvar k = 0; k < SqSteps; k++) begin : g_root
    localparam int unsigned Sh = 2 * (SqSteps - 1 - k);
    logic [SumW:0]    trial;
    logic [SumW:0]    cand;
    logic [RootW-1:0] root_nx;
    assign cand    = (SumW+1)'({rt_root_q[k], 2'b01}) << Sh;
    assign trial   = {1'b0, rt_rem_q[k]} - cand;
    assign root_nx = {rt_root_q[k][RootW-2:0], !trial[SumW]};
    if (k < SqSteps - 1) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (adv) begin
          rt_neg_q[k+1]  <= rt_neg_q[k];
          rt_mag_q[k+1]  <= rt_mag_q[k];
          rt_rem_q[k+1]  <= trial[SumW] ? rt_rem_q[k] : trial[SumW-1:0];
          rt_root_q[k+1] <= root_nx;
        end
      end
    end else begin : g_last
      // last root bit; loads the divider inputs
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_len_q[0] <= root_nx;
          for (int i = 0; i < 3; i++) begin
            dv_q[0][i].neg <= rt_neg_q[k][i];
            dv_q[0][i].num <= NumW'({rt_mag_q[k][i], 14'd0});
            dv_q[0][i].quo <= '0;
            dv_q[0][i].rem <= '0;
          end
        end
      end
    end
  end

  // ---------------- divide stages: restoring, 3 lanes ----------------
  always_comb begin
    for (int k = 0; k < DivSteps; k++)
      dv_dvs[k] = (dv_len_q[k] == '0) ? RootW'(1) : dv_len_q[k];
  end

  // a component never exceeds the floor root, so the quotient stays within
  // 16 bits; the first step takes the top 16 dividend bits at once
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_len_q[k+1] <= dv_len_q[k];
        for (int i = 0; i < 3; i++) begin
          logic [RootW+1:0] r2;
          logic [RootW+1:0] df;
          logic             sat;
          // first step loads the top 16 dividend bits as remainder
          if (k == 0) r2 = {2'b0, dv_q[k][i].num[NumW-1:NumW-RootW]};
          else        r2 = {dv_q[k][i].rem, dv_q[k][i].num[NumW-1]};
          df  = r2 - {2'b0, dv_dvs[k]};
          sat = dv_q[k][i].quo[QW-1];
          dv_q[k+1][i].neg <= dv_q[k][i].neg;
          dv_q[k+1][i].num <= (k == 0) ? (dv_q[k][i].num << RootW)
                                       : (dv_q[k][i].num << 1);
          if (!df[RootW+1]) begin
            dv_q[k+1][i].rem <= df[RootW:0];
            dv_q[k+1][i].quo <= sat ? dv_q[k][i].quo
                                    : {dv_q[k][i].quo[QW-2:0], 1'b1};
          end else begin
            dv_q[k+1][i].rem <= r2[RootW:0];
            dv_q[k+1][i].quo <= sat ? dv_q[k][i].quo
                                    : {dv_q[k][i].quo[QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStage-2:0], s_axis_tvalid};
    end
  end

  // ---------------- output register ----------------
  logic [63:0] out_q;
  logic        ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= vld_q[NStage-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        logic [QW-1:0] q;
        q = dv_q[DivSteps][i].quo;
        if (q > QOne) q = QOne;
        out_q[i*16 +: 16] <= dv_q[DivSteps][i].neg ? 16'(-q) : 16'(q);
      end
      out_q[63:48] <= dv_len_q[DivSteps];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  // ---------------- assertions ----------------
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:48] <= 16'd56755) else $error("length");
  a_x_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16384)) else $error("x");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[63:48] == 16'd0) |-> m_axis_tdata[47:0] == '0)
    else $error("zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv) |=> $stable(vld_q)) else $error("stall");

endmodule
